@@ sv/positional_ordered_list_defines.svh @@
// ----------------------------------------------------------------------------
// positional_ordered_list_defines
// Assertion macros shared by the ordered list modules. Each macro samples on
// the rising edge of clock and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ORDERED_LIST_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_DEFINES_SVH

`ifndef SYNTHESIS

// Assert a property on every clock edge outside reset
`define POL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Assert that a condition never holds outside reset
`define POL_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define POL_ASSERT(label, prop, msg)
`define POL_ASSERT_NEVER(label, cond, msg)

`endif

`endif

@@ sv/pol_pkg.sv @@
// ----------------------------------------------------------------------------
// pol_pkg
// Types, codes and sizes shared by the ordered list controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package pol_pkg;

   // Storage sizes
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = $clog2(CAPACITY);

   // Action codes
   localparam logic [2:0] ACT_INS_FRONT = 3'd0;
   localparam logic [2:0] ACT_INS_BACK  = 3'd1;
   localparam logic [2:0] ACT_INS_AT    = 3'd2;
   localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
   localparam logic [2:0] ACT_DEL_BACK  = 3'd4;
   localparam logic [2:0] ACT_DEL_AT    = 3'd5;
   localparam logic [2:0] ACT_DUMP      = 3'd6;

   // Status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_FULL    = 2'd1;
   localparam logic [1:0] STS_EMPTY   = 2'd2;
   localparam logic [1:0] STS_BAD_POS = 2'd3;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [6:0]         element_index;
      logic [6:0]         element_count;
      logic               last_of_run;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic exec;       // apply the accepted item and load its single result
      logic load_elem;  // load the next dumped element into the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic go_dump;    // accepted item is a dump of a non-empty list
      logic dump_last;  // dump pointer sits on the final stored element
   } stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

endpackage

@@ sv/positional_ordered_list.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list with front, back and positional insert and delete,
// plus an in-order dump.
// ----------------------------------------------------------------------------
// Each item is applied in the cycle it is accepted: an insert, delete or
// unknown action gives one result, and the next item may be accepted in
// the following cycle. A dump of a non-empty list of n elements gives n
// results after the accept cycle, one element per cycle from the single
// read port of the cell array; a dump of an empty list gives one result.
// A stalled result holds the block until it is taken. Cells are
// not cleared at reset; only stored elements are ever read back.
module positional_ordered_list (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pol_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pol_pkg::rsp_type rsp_item
);
   import pol_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence items and results
   pol_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold cells, count and the result register
   pol_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

endmodule

@@ sv/pol_datapath.sv @@
// ----------------------------------------------------------------------------
// pol_datapath
// Shifting cell array, element count, dump pointer and result register.
// Inserts and deletes shift all cells from the slot onward in parallel.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_defines.svh"

module pol_datapath (
   input  logic             clock,
   input  logic             reset,
   input  pol_pkg::req_type req_item,
   input  pol_pkg::cmd_type cmd,
   output pol_pkg::stat_type stat,
   output pol_pkg::rsp_type rsp_item
);
   import pol_pkg::*;

   logic signed [DATA_WIDTH-1:0] cells_ff [CAPACITY];
   logic signed [DATA_WIDTH-1:0] cells_in [CAPACITY];
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             dump_idx_ff, dump_idx_in;
   rsp_type                      rsp_ff, rsp_in;

   logic signed [DATA_WIDTH-1:0] new_value;
   logic [6:0]                   count_ext;
   logic                         full, empty;
   logic                         ins_pos_ok, del_pos_ok;
   logic                         do_ins, do_del;
   logic [IDX_W-1:0]             slot;
   logic [1:0]                   sts;
   logic signed [DATA_WIDTH-1:0] dump_cell;

   // Decode list condition and position range
   assign new_value  = DATA_WIDTH'(req_item.value);
   assign count_ext  = 7'(count_ff);
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign ins_pos_ok = (req_item.position != 7'd0) && (req_item.position <= count_ext + 7'd1);
   assign del_pos_ok = (req_item.position != 7'd0) && (req_item.position <= count_ext);

   // Pick the operation, its slot and its status
   always_comb begin
      do_ins = 1'b0;
      do_del = 1'b0;
      slot   = '0;
      sts    = STS_OK;
      case (req_item.action)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
            if (full) begin
               sts = STS_FULL;
            end else if (req_item.action == ACT_INS_AT && !ins_pos_ok) begin
               sts = STS_BAD_POS;
            end else begin
               do_ins = 1'b1;
               if (req_item.action == ACT_INS_BACK) begin
                  slot = IDX_W'(count_ff);
               end else if (req_item.action == ACT_INS_AT) begin
                  slot = IDX_W'(req_item.position - 7'd1);
               end
            end
         end
         ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
            if (empty) begin
               sts = STS_EMPTY;
            end else if (req_item.action == ACT_DEL_AT && !del_pos_ok) begin
               sts = STS_BAD_POS;
            end else begin
               do_del = 1'b1;
               if (req_item.action == ACT_DEL_BACK) begin
                  slot = IDX_W'(count_ff - CNT_W'(1));
               end else if (req_item.action == ACT_DEL_AT) begin
                  slot = IDX_W'(req_item.position - 7'd1);
               end
            end
         end
         ACT_DUMP: begin
            if (empty) begin
               sts = STS_EMPTY;
            end
         end
         default: begin
            sts = STS_OK;
         end
      endcase
   end

   // Shift cells open for an insert or closed for a delete
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
      end
      if (cmd.exec && do_ins) begin
         cells_in[0] = (slot == '0) ? new_value : cells_ff[0];
         for (int i = 1; i < CAPACITY; i++) begin
            if (IDX_W'(i) == slot) begin
               cells_in[i] = new_value;
            end else if (IDX_W'(i) > slot) begin
               cells_in[i] = cells_ff[i-1];
            end
         end
      end else if (cmd.exec && do_del) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= slot) begin
               cells_in[i] = cells_ff[i+1];
            end
         end
      end
   end

   // Advance count and dump pointer
   always_comb begin
      count_in    = count_ff;
      dump_idx_in = dump_idx_ff;
      if (cmd.exec) begin
         dump_idx_in = '0;
         if (do_ins) begin
            count_in = count_ff + CNT_W'(1);
         end else if (do_del) begin
            count_in = count_ff - CNT_W'(1);
         end
      end else if (cmd.load_elem) begin
         dump_idx_in = dump_idx_ff + IDX_W'(1);
      end
   end

   // Load the result register
   assign dump_cell = cells_ff[dump_idx_ff];

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.exec) begin
         rsp_in.status        = sts;
         rsp_in.element       = '0;
         rsp_in.element_index = '0;
         rsp_in.element_count = 7'(count_in);
         rsp_in.last_of_run   = 1'b1;
      end else if (cmd.load_elem) begin
         rsp_in.status        = STS_OK;
         rsp_in.element       = 32'(dump_cell);
         rsp_in.element_index = 7'(dump_idx_ff) + 7'd1;
         rsp_in.element_count = count_ext;
         rsp_in.last_of_run   = stat.dump_last;
      end
   end

   assign stat.go_dump   = (req_item.action == ACT_DUMP) && !empty;
   assign stat.dump_last = (dump_idx_ff == IDX_W'(count_ff - CNT_W'(1)));
   assign rsp_item       = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         dump_idx_ff <= '0;
      end else begin
         count_ff    <= count_in;
         dump_idx_ff <= dump_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      rsp_ff <= rsp_in;
   end

   `POL_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "element count beyond capacity")
   `POL_ASSERT(a_count_only_on_exec, !cmd.exec |=> $stable(count_ff), "count moved without an item")
   `POL_ASSERT(a_dump_advance, cmd.load_elem |=> dump_idx_ff == $past(dump_idx_ff) + IDX_W'(1), "dump pointer did not advance")

endmodule

@@ sv/pol_controller.sv @@
// ----------------------------------------------------------------------------
// pol_controller
// Sequences items: applies each accepted item, streams dumps one element a
// cycle while results are taken, and owns the result valid flag.
// ----------------------------------------------------------------------------
`include "positional_ordered_list_defines.svh"

module pol_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  pol_pkg::stat_type stat,
   output pol_pkg::cmd_type  cmd
);
   import pol_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && slot_free && stat.go_dump) begin
               state_in = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (slot_free && stat.dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd.exec      = 1'b0;
      cmd.load_elem = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = slot_free;
            cmd.exec  = req_valid && slot_free;
         end
         ST_DUMP: begin
            cmd.load_elem = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Hold the result until taken, set it when a new one loads
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((cmd.exec && !stat.go_dump) || cmd.load_elem) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `POL_ASSERT_NEVER(a_no_accept_in_dump, state_ff == ST_DUMP && req_ready, "item taken during dump")
   `POL_ASSERT(a_exec_result, cmd.exec |=> rsp_valid_ff || state_ff == ST_DUMP, "accepted item left no result")
   `POL_ASSERT(a_dump_ends, cmd.load_elem && stat.dump_last |=> state_ff == ST_IDLE && rsp_valid_ff, "dump did not end on final element")

endmodule

@@ tb/positional_ordered_list_test.sv @@
// ----------------------------------------------------------------------------
// positional_ordered_list_test
// Self-checking bench for the bounded ordered list. A directed table covers
// the empty, full and bad-position cases, the extreme values and every
// action. A long random run of grow and shrink phases follows. Each accepted
// item is replayed on a shadow copy of the list, and every result is compared
// field by field with the oldest expected one. Both channels idle at random,
// the receiver holds off once for a long stretch, and the sender waits for
// all owed results to drain after the table and once during the random run.
// ----------------------------------------------------------------------------
module positional_ordered_list_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pol_pkg::*;

   // Action code that the block does not define
   localparam logic [2:0] ACT_UNDEFINED = 3'd7;
   localparam int RAND_ITEMS      = 380;
   localparam int RSP_HOLD_CYCLES = 80;

   typedef enum logic {
      ROW_ITEM,
      ROW_FILL
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      req;
      bit           typed;
      rsp_type      want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_item;

   // Shadow copy of the list contents
   logic signed [DATA_WIDTH-1:0] list_cells [CAPACITY];
   int                           list_count = 0;

   // Results still owed by the block, oldest first
   rsp_type awaited_rsp [$];

   int error_count   = 0;
   bit quiet_send    = 1'b0;
   bit quiet_recv    = 1'b0;
   bit rsp_hold_req  = 1'b0;

   positional_ordered_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one accepted item to the shadow list and queue its results
   function automatic void list_apply(input req_type r);
      rsp_type res;
      int      slot;
      int      i;
      res             = '0;
      res.status      = STS_OK;
      res.last_of_run = 1'b1;
      case (r.action)
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
            if (list_count >= CAPACITY) begin
               res.status = STS_FULL;
            end else if (r.action == ACT_INS_AT &&
                         (r.position < 1 || r.position > list_count + 1)) begin
               res.status = STS_BAD_POS;
            end else begin
               if (r.action == ACT_INS_FRONT)
                  slot = 0;
               else if (r.action == ACT_INS_BACK)
                  slot = list_count;
               else
                  slot = r.position - 1;
               for (i = list_count; i > slot; i--)
                  list_cells[i] = list_cells[i-1];
               list_cells[slot] = r.value;
               list_count++;
            end
         end
         ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
            if (list_count == 0) begin
               res.status = STS_EMPTY;
            end else if (r.action == ACT_DEL_AT &&
                         (r.position < 1 || r.position > list_count)) begin
               res.status = STS_BAD_POS;
            end else begin
               if (r.action == ACT_DEL_FRONT)
                  slot = 0;
               else if (r.action == ACT_DEL_BACK)
                  slot = list_count - 1;
               else
                  slot = r.position - 1;
               for (i = slot; i + 1 < list_count; i++)
                  list_cells[i] = list_cells[i+1];
               list_count--;
            end
         end
         ACT_DUMP: begin
            if (list_count == 0) begin
               res.status = STS_EMPTY;
            end else begin
               // Stream every stored element, last mark on the final one
               for (i = 0; i < list_count; i++) begin
                  res.element       = list_cells[i];
                  res.element_index = 7'(i + 1);
                  res.element_count = 7'(list_count);
                  res.last_of_run   = (i + 1 == list_count);
                  awaited_rsp.push_back(res);
               end
               return;
            end
         end
         default: ;
      endcase
      res.element_count = 7'(list_count);
      awaited_rsp.push_back(res);
   endfunction

   function automatic req_type mk_req(input logic [2:0] act,
                                      input logic signed [31:0] val,
                                      input logic [6:0] pos);
      req_type r;
      r.action   = act;
      r.value    = val;
      r.position = pos;
      return r;
   endfunction

   // One table row; a typed row carries its single expected result
   function automatic stim_row_type row(input logic [2:0] act,
                                        input logic signed [31:0] val,
                                        input logic [6:0] pos,
                                        input bit typed,
                                        input logic [1:0] sts,
                                        input logic [6:0] cnt);
      stim_row_type s;
      s.kind                 = ROW_ITEM;
      s.req                  = mk_req(act, val, pos);
      s.typed                = typed;
      s.want                 = '0;
      s.want.status          = sts;
      s.want.element_count   = cnt;
      s.want.last_of_run     = 1'b1;
      return s;
   endfunction

   // Offer one item from a falling edge, hold it until accepted
   task automatic drive_item(input req_type r);
      int gap;
      gap = quiet_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      list_apply(r);
      @(negedge clock);
   endtask

   // Withdraw the offer and wait for every owed result
   task automatic wait_drained();
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic void note_mismatch(input string name, input longint want,
                                         input longint got);
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
   endfunction

   // Compare each taken result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("result with none expected: %p", rsp_item);
            error_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_item.status !== want.status)
               note_mismatch("status", want.status, rsp_item.status);
            if (rsp_item.element !== want.element)
               note_mismatch("element", want.element, rsp_item.element);
            if (rsp_item.element_index !== want.element_index)
               note_mismatch("element_index", want.element_index,
                             rsp_item.element_index);
            if (rsp_item.element_count !== want.element_count)
               note_mismatch("element_count", want.element_count,
                             rsp_item.element_count);
            if (rsp_item.last_of_run !== want.last_of_run)
               note_mismatch("last_of_run", want.last_of_run, rsp_item.last_of_run);
         end
      end
   end

   // Result side: random stall per item, one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
         end
         stall = quiet_recv ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Stimulus: directed table, then grow and shrink phases at random
   initial begin
      stim_row_type steps [$];
      stim_row_type s;
      int           roll;
      int           seg_left;
      bit           grow;
      logic [2:0]   act;
      logic [6:0]   pos;
      logic signed [31:0] val;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty list: every delete and the dump report empty, inserts at 0 and 2 are bad
      steps.push_back(row(ACT_DUMP,      0, 0,   1, STS_EMPTY,   0));
      steps.push_back(row(ACT_DEL_FRONT, 0, 0,   1, STS_EMPTY,   0));
      steps.push_back(row(ACT_DEL_BACK,  0, 0,   1, STS_EMPTY,   0));
      steps.push_back(row(ACT_DEL_AT,    0, 1,   1, STS_EMPTY,   0));
      steps.push_back(row(ACT_INS_AT,    5, 0,   1, STS_BAD_POS, 0));
      steps.push_back(row(ACT_INS_AT,    5, 2,   1, STS_BAD_POS, 0));
      // Extreme values, append through position count plus one
      steps.push_back(row(ACT_INS_FRONT, 32'h7FFF_FFFF, 0, 1, STS_OK, 1));
      steps.push_back(row(ACT_INS_BACK,  32'h8000_0000, 0, 1, STS_OK, 2));
      steps.push_back(row(ACT_INS_AT,    -1,  3,   1, STS_OK,      3));
      steps.push_back(row(ACT_INS_AT,    0,   1,   1, STS_OK,      4));
      steps.push_back(row(ACT_INS_AT,    7,   127, 1, STS_BAD_POS, 4));
      steps.push_back(row(ACT_INS_AT,    32'h5A5A_5A5A, 2, 0, STS_OK, 0));
      steps.push_back(row(ACT_DUMP,      0,   0,   0, STS_OK,      0));
      steps.push_back(row(ACT_DEL_AT,    0,   0,   1, STS_BAD_POS, 5));
      steps.push_back(row(ACT_DEL_AT,    0,   6,   1, STS_BAD_POS, 5));
      steps.push_back(row(ACT_DEL_AT,    0,   2,   0, STS_OK,      0));
      steps.push_back(row(ACT_DEL_FRONT, 0,   0,   0, STS_OK,      0));
      steps.push_back(row(ACT_DEL_BACK,  0,   0,   0, STS_OK,      0));
      steps.push_back(row(ACT_UNDEFINED, -1,  127, 1, STS_OK,      2));
      steps.push_back(row(ACT_DUMP,      0,   0,   0, STS_OK,      0));
      // Fill to capacity, then full wins over any position
      s      = row(ACT_INS_BACK, 0, 0, 0, STS_OK, 0);
      s.kind = ROW_FILL;
      steps.push_back(s);
      steps.push_back(row(ACT_INS_FRONT, 1, 0,   1, STS_FULL, 7'(CAPACITY)));
      steps.push_back(row(ACT_INS_BACK,  1, 0,   1, STS_FULL, 7'(CAPACITY)));
      steps.push_back(row(ACT_INS_AT,    1, 0,   1, STS_FULL, 7'(CAPACITY)));
      steps.push_back(row(ACT_INS_AT,    1, 7'(CAPACITY + 1), 1, STS_FULL,
                          7'(CAPACITY)));
      steps.push_back(row(ACT_DUMP,      0, 0,   0, STS_OK, 0));
      steps.push_back(row(ACT_DEL_AT,    0, 7'(CAPACITY), 0, STS_OK, 0));
      steps.push_back(row(ACT_DEL_AT,    0, 7'(CAPACITY), 1, STS_BAD_POS,
                          7'(CAPACITY - 1)));
      steps.push_back(row(ACT_INS_AT,    32'h0000_FFFF, 7'(CAPACITY), 0, STS_OK, 0));

      foreach (steps[k]) begin
         if (steps[k].kind == ROW_FILL) begin
            while (list_count < CAPACITY)
               drive_item(mk_req(ACT_INS_BACK, $urandom, 7'($urandom_range(0, 127))));
         end else begin
            drive_item(steps[k].req);
            if (steps[k].typed)
               awaited_rsp[awaited_rsp.size()-1] = steps[k].want;
         end
      end

      // Hold the sender until the directed part has drained
      wait_drained();

      grow     = 1'b1;
      seg_left = 0;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         // Switch between grow and shrink phases, with bursts of no idling
         if (seg_left == 0) begin
            grow       = !grow;
            seg_left   = $urandom_range(20, 50);
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
         end
         seg_left--;
         if (n == 120)
            rsp_hold_req = 1'b1;
         if (n == 260)
            wait_drained();

         roll = $urandom_range(0, 99);
         if (roll < 8)
            act = ACT_DUMP;
         else if (roll < 10)
            act = ACT_UNDEFINED;
         else if (roll < (grow ? 72 : 34))
            act = 3'($urandom_range(ACT_INS_FRONT, ACT_INS_AT));
         else
            act = 3'($urandom_range(ACT_DEL_FRONT, ACT_DEL_AT));

         // Mostly in-range positions, the rest noise over the whole field
         pos = 7'($urandom_range(0, 127));
         if ($urandom_range(0, 99) < 85) begin
            if (act == ACT_INS_AT)
               pos = 7'($urandom_range(1, list_count + 1));
            else if (act == ACT_DEL_AT && list_count > 0)
               pos = 7'($urandom_range(1, list_count));
         end

         case ($urandom_range(0, 19))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = 0;
            3:       val = -1;
            default: val = $urandom;
         endcase

         drive_item(mk_req(act, val, pos));
      end
      req_valid = 1'b0;

      // Drain, then keep watching for stray results before reporting
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (CAPACITY + 4) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Abandon a hung run
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule
